// File: sv/u2r565_pkg.sv
// Shared types and color-matrix constants for the UYVY/RGB24 to RGB565 converter.
`timescale 1ns / 1ps

package u2r565_pkg;

  // Pixel input format selected by the mode register.
  typedef enum logic {
    MODE_UYVY  = 1'b0,
    MODE_RGB24 = 1'b1
  } pixel_mode_t;

  localparam logic [7:0] CHROMA_BIAS = 8'd128;

  // Q16 color-matrix coefficients, held as 18-bit signed so that the largest one fits.
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd91881;
  localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd46792;
  localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd21889;
  localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd116129;
  localparam int FRAC_BITS = 16;

  // Centered chroma and the products derived from it.
  localparam int CHROMA_W = 9;
  localparam int PROD_W   = COEF_W + CHROMA_W;
  localparam int DELTA_W  = PROD_W - FRAC_BITS;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic       frame_end_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
    logic        second_valid;
    logic        frame_end_out;
  } out_item_t;

  // Per-request payload between the matrix stages and the packing stage.
  typedef struct packed {
    pixel_mode_t               mode;
    logic [7:0]                byte_zero;
    logic [7:0]                byte_one;
    logic [7:0]                byte_two;
    logic [7:0]                byte_three;
    logic                      frame_end;
    logic signed [DELTA_W-1:0] delta_r;
    logic signed [DELTA_W-1:0] delta_g;
    logic signed [DELTA_W-1:0] delta_b;
  } delta_t;

endpackage

// File: sv/uyvy_to_rgb565_converter.sv
// Throughput: one request per clock while in_stall is low; each of the three
// register stages (chroma centering, coefficient multiply, saturate and pack)
// moves on independently. Back-pressure from out_stall reaches in_stall only
// once every stage is full. Reset (synchronous, rst_n low) empties the pipeline
// and sets UYVY mode.
`timescale 1ns / 1ps

module uyvy_to_rgb565_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u2r565_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u2r565_pkg::out_item_t out_item
);
  import u2r565_pkg::*;

  pixel_mode_t pixel_mode_r;
  logic        mid_valid;
  logic        mid_stall;
  delta_t      mid_delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= MODE_UYVY;
    end else if (cfg_we) begin
      pixel_mode_r <= pixel_mode_t'(cfg_data);
    end
  end

  u2r565_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (pixel_mode_r),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (in_item),
    .dn_valid (mid_valid),
    .dn_stall (mid_stall),
    .dn_delta (mid_delta)
  );

  u2r565_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_stall (mid_stall),
    .up_delta (mid_delta),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_item  (out_item)
  );

`ifndef ASSERT_OFF
  // The input side may only hold when the output side is holding a result.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A request accepted while out_stall stays low produces a valid result at the outputs.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing three cycles after request");

  // A result without a second pixel carries zero in that field.
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.second_valid) |-> (out_item.pixel_second == 16'd0))
    else $error("second pixel not cleared");

  // User must change mode only while idle (unenforced); results follow current mode.
  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.second_valid == (pixel_mode_r == MODE_UYVY)))
    else $error("result format does not match pixel mode");
`endif

endmodule

// File: sv/u2r565_matrix.sv
// Chroma centering and coefficient multiply stages of the converter.
`timescale 1ns / 1ps

module u2r565_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2r565_pkg::pixel_mode_t mode,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  u2r565_pkg::in_item_t up_item,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output u2r565_pkg::delta_t   dn_delta
);
  import u2r565_pkg::*;

  typedef struct packed {
    pixel_mode_t                mode;
    in_item_t                   item;
    logic signed [CHROMA_W-1:0] u;
    logic signed [CHROMA_W-1:0] v;
  } chroma_t;

  logic    s1_valid_r;
  chroma_t s1_data_r;
  chroma_t s1_data_nxt;
  logic    s1_stall;

  logic    s2_valid_r;
  delta_t  s2_data_r;
  delta_t  s2_data_nxt;
  logic    s2_stall;

  logic signed [PROD_W-1:0] prod_rv;
  logic signed [PROD_W-1:0] prod_gv;
  logic signed [PROD_W-1:0] prod_gu;
  logic signed [PROD_W-1:0] prod_bu;

  // A stage holds only when it is full and the stage after it holds.
  assign s2_stall = s2_valid_r & dn_stall;
  assign s1_stall = s1_valid_r & s2_stall;
  assign up_stall = s1_stall;

  // Subtracting the bias of 128 from a byte is a flip of its top bit.
  always_comb begin
    s1_data_nxt.mode = mode;
    s1_data_nxt.item = up_item;
    s1_data_nxt.u    = $signed({up_item.byte_zero[7] ? 1'b0 : 1'b1,
                                ~up_item.byte_zero[7], up_item.byte_zero[6:0]});
    s1_data_nxt.v    = $signed({up_item.byte_two[7] ? 1'b0 : 1'b1,
                                ~up_item.byte_two[7], up_item.byte_two[6:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid_r <= up_valid;
    end
    if (!s1_stall && up_valid) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  // Taking the top bits of the product is an arithmetic shift, which floors.
  assign prod_rv = COEF_RV * s1_data_r.v;
  assign prod_gv = COEF_GV * s1_data_r.v;
  assign prod_gu = COEF_GU * s1_data_r.u;
  assign prod_bu = COEF_BU * s1_data_r.u;

  always_comb begin
    s2_data_nxt.mode       = s1_data_r.mode;
    s2_data_nxt.byte_zero  = s1_data_r.item.byte_zero;
    s2_data_nxt.byte_one   = s1_data_r.item.byte_one;
    s2_data_nxt.byte_two   = s1_data_r.item.byte_two;
    s2_data_nxt.byte_three = s1_data_r.item.byte_three;
    s2_data_nxt.frame_end  = s1_data_r.item.frame_end_in;
    s2_data_nxt.delta_r    = prod_rv[PROD_W-1:FRAC_BITS];
    s2_data_nxt.delta_g    = DELTA_W'(prod_gv[PROD_W-1:FRAC_BITS] +
                                      prod_gu[PROD_W-1:FRAC_BITS]);
    s2_data_nxt.delta_b    = prod_bu[PROD_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_stall) begin
      s2_valid_r <= s1_valid_r;
    end
    if (!s2_stall && s1_valid_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_delta = s2_data_r;

endmodule

// File: sv/u2r565_pack.sv
// Luma add, saturation and RGB565 packing stage with the output register.
`timescale 1ns / 1ps

module u2r565_pack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  u2r565_pkg::delta_t    up_delta,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output u2r565_pkg::out_item_t dn_item
);
  import u2r565_pkg::*;

  logic      valid_r;
  out_item_t item_r;
  out_item_t item_nxt;
  logic      stall;

  function automatic logic [7:0] clamp8(input logic signed [DELTA_W-1:0] x);
    logic [7:0] res;
    if (x[DELTA_W-1]) begin
      res = 8'd0;
    end else if (x[DELTA_W-2:8] != '0) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] yuv_pixel(input logic [7:0] y,
                                            input logic signed [DELTA_W-1:0] dr,
                                            input logic signed [DELTA_W-1:0] dg,
                                            input logic signed [DELTA_W-1:0] db);
    logic signed [DELTA_W-1:0] ys;
    ys = $signed({{(DELTA_W-8){1'b0}}, y});
    return pack565(clamp8(DELTA_W'(ys + dr)), clamp8(DELTA_W'(ys - dg)),
                   clamp8(DELTA_W'(ys + db)));
  endfunction

  assign stall    = valid_r & dn_stall;
  assign up_stall = stall;

  always_comb begin
    item_nxt.frame_end_out = up_delta.frame_end;
    case (up_delta.mode)
      MODE_RGB24: begin
        item_nxt.pixel_first  = pack565(up_delta.byte_zero, up_delta.byte_one,
                                        up_delta.byte_two);
        item_nxt.pixel_second = 16'd0;
        item_nxt.second_valid = 1'b0;
      end
      default: begin
        item_nxt.pixel_first  = yuv_pixel(up_delta.byte_one, up_delta.delta_r,
                                          up_delta.delta_g, up_delta.delta_b);
        item_nxt.pixel_second = yuv_pixel(up_delta.byte_three, up_delta.delta_r,
                                          up_delta.delta_g, up_delta.delta_b);
        item_nxt.second_valid = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall) begin
      valid_r <= up_valid;
    end
    if (!stall && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule
